FILE: hdl/gcd_pkg.sv
// Shared constants and helpers for the great-circle distance datapath.
// No dependencies; used by great_circle_distance.sv.
`timescale 1ns / 1ps
`default_nettype none

package gcd_pkg;

    localparam int CORDIC_STAGES_DEF   = 24;
    localparam int ANGLE_FRAC_BITS_DEF = 16;

    localparam int RADIUS_W = 20;
    localparam int DIST_W   = 26;
    localparam int ANG_W    = 26;   // sign-extended angle, holds lon2 - lon1
    localparam int MAG_W    = 23;   // |angle| after folding, <= 90 degrees

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 20'd101888;

    // register index decoded from paddr[2]
    localparam logic REG_RADIUS = 1'b0;

    localparam logic signed [27:0] FULL_TURN    = 28'sd23592960;
    localparam logic signed [27:0] HALF_TURN    = 28'sd11796480;
    localparam logic signed [27:0] QUARTER_TURN = 28'sd5898240;
    localparam logic signed [27:0] THREE_QUARTER = 28'sd17694720;

    localparam logic [31:0] PI_Q30   = 32'd3373259426;
    localparam logic [31:0] GAIN_Q30 = 32'd652032874;

    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

    // Q30 constant rounded to w fraction bits (sh = 30 - w, or 31 - w for half)
    function automatic logic [32:0] q30_round(logic [31:0] v, int sh);
        logic [32:0] s;
        s = {1'b0, v} + (33'd1 << (sh - 1));
        return s >> sh;
    endfunction

    function automatic logic [32:0] atan_w(logic [4:0] i, int w);
        return q30_round(ATAN_Q30[i], 30 - w);
    endfunction

endpackage

`default_nettype wire

FILE: hdl/great_circle_distance.sv
// Great-circle distance by the spherical law of cosines, fully pipelined.
// Depends on gcd_pkg (constants, arctangent table, rounding helpers).
// Channel  | signals                                   | dir | notes
// ---------+-------------------------------------------+-----+------------------------
// in       | in_valid/in_ready, two lat/lon pairs      | in  | one transfer per cycle
// out      | out_valid/out_ready, distance             | out | registered result
// apb      | psel/penable/pwrite/paddr/pwdata/prdata   | in  | sphere_radius at 0x0
// Throughput is one item per cycle while the output is not stalled; the pipeline depth
// is set by the two CORDIC chains and the bit-per-stage square root.
// All stages advance together whenever the output register is empty or being taken,
// so a stall freezes the whole pipe and nothing is lost or repeated.
// rst_n clears the valid bits and loads the default radius (6368 km).
`timescale 1ns / 1ps
`default_nettype none

module great_circle_distance #(
    parameter int CORDIC_STAGES   = gcd_pkg::CORDIC_STAGES_DEF,
    parameter int ANGLE_FRAC_BITS = gcd_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [23:0]            first_latitude,
    input  wire logic signed [24:0]            first_longitude,
    input  wire logic signed [23:0]            second_latitude,
    input  wire logic signed [24:0]            second_longitude,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [gcd_pkg::DIST_W-1:0]         distance,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int N   = CORDIC_STAGES;
    localparam int W   = ANGLE_FRAC_BITS;
    localparam int CW  = W + 3;
    localparam int SH  = 46 - W;
    localparam int PW  = gcd_pkg::MAG_W + 32;
    localparam int QW  = PW - SH + 1;
    localparam int K   = QW + 8;
    localparam int MW  = K - 7;
    localparam int VW  = 2 * W + 2;
    localparam int AW  = W + 2;
    localparam int NPW = gcd_pkg::RADIUS_W + AW;
    localparam int LAT = 2 * N + W + 16;

    localparam logic [MW-1:0] RECIP = MW'((64'd1 << K) / 180 + 64'd1);
    localparam logic signed [CW-1:0] GAIN_W  =
        CW'(gcd_pkg::q30_round(gcd_pkg::GAIN_Q30, 30 - W));
    localparam logic signed [CW-1:0] PI_W    =
        CW'(gcd_pkg::q30_round(gcd_pkg::PI_Q30, 30 - W));
    localparam logic signed [CW-1:0] HALFPI_W =
        CW'(gcd_pkg::q30_round(gcd_pkg::PI_Q30, 31 - W));
    localparam logic signed [2*CW-1:0] RHALF = (2 * CW)'(1) << (W - 1);
    localparam logic signed [AW-1:0] ONE_T = AW'(1) << W;
    localparam logic [VW-1:0] ONE_SQ = VW'(1) << (2 * W);
    localparam logic [NPW-1:0] DHALF = NPW'(1) << (W - 5);

    logic adv;
    logic [LAT-1:0] vld_reg;
    logic [gcd_pkg::RADIUS_W-1:0] radius_reg;

    assign adv       = !vld_reg[LAT-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[LAT-1];
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == gcd_pkg::REG_RADIUS) ? 32'(radius_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            radius_reg <= gcd_pkg::RADIUS_RESET;
        end
        else
        begin
            if (adv)
            begin
                vld_reg <= {vld_reg[LAT-2:0], in_valid};
            end
            if (psel && penable && pwrite && paddr[2] == gcd_pkg::REG_RADIUS)
            begin
                radius_reg <= pwdata[gcd_pkg::RADIUS_W-1:0];
            end
        end
    end

    // ---------------- angle front end, three lanes: lat1, lat2, dlon
    logic signed [gcd_pkg::ANG_W-1:0] a_ang_reg [3];
    logic [24:0]                      b_u_reg [3];
    logic [gcd_pkg::MAG_W-1:0]        c_mag_reg [3];
    logic [2:0]                       c_sgn_reg, c_neg_reg;
    logic [PW-1:0]                    d_prod_reg [3];
    logic [2:0]                       d_sgn_reg, d_neg_reg;
    logic [QW+MW-1:0]                 e_qm_reg [3];
    logic [2:0]                       e_sgn_reg, e_neg_reg;

    logic signed [CW-1:0] rx_reg [3][N+1];
    logic signed [CW-1:0] ry_reg [3][N+1];
    logic signed [CW-1:0] rz_reg [3][N+1];
    logic [2:0]           rneg_reg [N+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_ang_reg[0] <= gcd_pkg::ANG_W'(first_latitude);
            a_ang_reg[1] <= gcd_pkg::ANG_W'(second_latitude);
            a_ang_reg[2] <= gcd_pkg::ANG_W'(second_longitude)
                          - gcd_pkg::ANG_W'(first_longitude);
        end
    end

    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        logic signed [27:0] v_ext, u_ext, r_ext;
        logic [gcd_pkg::MAG_W-1:0] mag;
        logic r_neg;
        logic [QW-1:0] q;

        // modulo one turn into [0, 360)
        always_comb
        begin
            v_ext = 28'(a_ang_reg[l]);
            if (v_ext < -gcd_pkg::FULL_TURN)
            begin
                u_ext = v_ext + (gcd_pkg::FULL_TURN <<< 1);
            end
            else if (v_ext < 0)
            begin
                u_ext = v_ext + gcd_pkg::FULL_TURN;
            end
            else if (v_ext < gcd_pkg::FULL_TURN)
            begin
                u_ext = v_ext;
            end
            else
            begin
                u_ext = v_ext - gcd_pkg::FULL_TURN;
            end
        end

        // fold into [-90, 90]; second and third quadrants flip sin and cos
        always_comb
        begin
            r_ext = $signed({3'b000, b_u_reg[l]});
            r_neg = 1'b0;
            if (r_ext > gcd_pkg::QUARTER_TURN && r_ext < gcd_pkg::THREE_QUARTER)
            begin
                r_ext = r_ext - gcd_pkg::HALF_TURN;
                r_neg = 1'b1;
            end
            else if (r_ext >= gcd_pkg::THREE_QUARTER)
            begin
                r_ext = r_ext - gcd_pkg::FULL_TURN;
            end
            mag = r_ext[27] ? gcd_pkg::MAG_W'(-r_ext) : gcd_pkg::MAG_W'(r_ext);
        end

        // round(mag * pi / 180) = floor(((mag*pi_q30 >> SH) + 90) / 180)
        assign q = QW'(d_prod_reg[l] >> SH) + QW'(90);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                b_u_reg[l]   <= u_ext[24:0];
                c_mag_reg[l] <= mag;
                c_sgn_reg[l] <= r_ext[27];
                c_neg_reg[l] <= r_neg;
                d_prod_reg[l] <= PW'(c_mag_reg[l]) * PW'(gcd_pkg::PI_Q30);
                d_sgn_reg[l] <= c_sgn_reg[l];
                d_neg_reg[l] <= c_neg_reg[l];
                e_qm_reg[l]  <= (QW + MW)'(q) * (QW + MW)'(RECIP);
                e_sgn_reg[l] <= d_sgn_reg[l];
                e_neg_reg[l] <= d_neg_reg[l];
                rx_reg[l][0] <= GAIN_W;
                ry_reg[l][0] <= '0;
                rz_reg[l][0] <= e_sgn_reg[l] ? -CW'(e_qm_reg[l] >> K)
                                             :  CW'(e_qm_reg[l] >> K);
            end
        end

        // rotation-mode CORDIC, one stage per register
        for (genvar i = 0; i < N; i++)
        begin : g_rot
            localparam logic signed [CW-1:0] ATAN_I = CW'(gcd_pkg::atan_w(5'(i), W));
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (rz_reg[l][i] >= 0)
                    begin
                        rx_reg[l][i+1] <= rx_reg[l][i] - (ry_reg[l][i] >>> i);
                        ry_reg[l][i+1] <= ry_reg[l][i] + (rx_reg[l][i] >>> i);
                        rz_reg[l][i+1] <= rz_reg[l][i] - ATAN_I;
                    end
                    else
                    begin
                        rx_reg[l][i+1] <= rx_reg[l][i] + (ry_reg[l][i] >>> i);
                        ry_reg[l][i+1] <= ry_reg[l][i] - (rx_reg[l][i] >>> i);
                        rz_reg[l][i+1] <= rz_reg[l][i] + ATAN_I;
                    end
                end
            end
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_negpipe
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rneg_reg[i+1] <= rneg_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rneg_reg[0] <= e_neg_reg;
        end
    end

    // ---------------- law-of-cosines term
    logic signed [CW-1:0]   g_c_reg [3];
    logic signed [CW-1:0]   g_s_reg [3];
    logic signed [CW-1:0]   h_p1_reg, h_p2_reg, h_cl_reg;
    logic signed [AW-1:0]   i_t_reg, j_t_reg;
    logic [VW-1:0]          j_sq_reg;
    logic signed [2*CW-1:0] m1, m2, m3;
    logic signed [CW:0]     tsum;
    logic signed [AW-1:0]   tclamp;
    logic signed [2*AW-1:0] tsq;

    assign m1  = (g_c_reg[0] * g_c_reg[1] + RHALF) >>> W;
    assign m2  = (g_s_reg[0] * g_s_reg[1] + RHALF) >>> W;
    assign m3  = (h_p1_reg * h_cl_reg + RHALF) >>> W;
    assign tsum = (CW + 1)'(m3) + (CW + 1)'(h_p2_reg);
    assign tsq  = i_t_reg * i_t_reg;

    always_comb
    begin
        if (tsum > (CW + 1)'(ONE_T))
        begin
            tclamp = ONE_T;
        end
        else if (tsum < -(CW + 1)'(ONE_T))
        begin
            tclamp = -ONE_T;
        end
        else
        begin
            tclamp = AW'(tsum);
        end
    end

    for (genvar l = 0; l < 3; l++)
    begin : g_sign
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                g_c_reg[l] <= rneg_reg[N][l] ? -rx_reg[l][N] : rx_reg[l][N];
                g_s_reg[l] <= rneg_reg[N][l] ? -ry_reg[l][N] : ry_reg[l][N];
            end
        end
    end

    // ---------------- sqrt(1 - t^2), one result bit per stage
    logic [VW-1:0]        sv_reg [W+2];
    logic [VW-1:0]        sr_reg [W+2];
    logic signed [AW-1:0] st_reg [W+2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_p1_reg  <= m1[CW-1:0];
            h_p2_reg  <= m2[CW-1:0];
            h_cl_reg  <= g_c_reg[2];
            i_t_reg   <= tclamp;
            j_sq_reg  <= VW'(tsq);
            j_t_reg   <= i_t_reg;
            sv_reg[0] <= ONE_SQ - j_sq_reg;
            sr_reg[0] <= '0;
            st_reg[0] <= j_t_reg;
        end
    end

    for (genvar j = 0; j <= W; j++)
    begin : g_sqrt
        localparam logic [VW-1:0] BIT = VW'(1) << (2 * (W - j));
        logic [VW-1:0] trial;
        assign trial = sr_reg[j] + BIT;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_reg[j+1] <= st_reg[j];
                if (sv_reg[j] >= trial)
                begin
                    sv_reg[j+1] <= sv_reg[j] - trial;
                    sr_reg[j+1] <= (sr_reg[j] >> 1) + BIT;
                end
                else
                begin
                    sv_reg[j+1] <= sv_reg[j];
                    sr_reg[j+1] <= sr_reg[j] >> 1;
                end
            end
        end
    end

    // ---------------- arccos by vectoring-mode CORDIC
    logic signed [CW-1:0] vx_reg [N+1];
    logic signed [CW-1:0] vy_reg [N+1];
    logic signed [CW-1:0] vz_reg [N+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (st_reg[W+1] < 0)
            begin
                vx_reg[0] <= CW'(sr_reg[W+1]);
                vy_reg[0] <= -CW'(st_reg[W+1]);
                vz_reg[0] <= HALFPI_W;
            end
            else
            begin
                vx_reg[0] <= CW'(st_reg[W+1]);
                vy_reg[0] <= CW'(sr_reg[W+1]);
                vz_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_vec
        localparam logic signed [CW-1:0] ATAN_I = CW'(gcd_pkg::atan_w(5'(i), W));
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (vy_reg[i] >= 0)
                begin
                    vx_reg[i+1] <= vx_reg[i] + (vy_reg[i] >>> i);
                    vy_reg[i+1] <= vy_reg[i] - (vx_reg[i] >>> i);
                    vz_reg[i+1] <= vz_reg[i] + ATAN_I;
                end
                else
                begin
                    vx_reg[i+1] <= vx_reg[i] - (vy_reg[i] >>> i);
                    vy_reg[i+1] <= vy_reg[i] + (vx_reg[i] >>> i);
                    vz_reg[i+1] <= vz_reg[i] - ATAN_I;
                end
            end
        end
    end

    // ---------------- clamp angle, scale by radius, round to 1/256 km
    logic [AW-1:0]  m_a_reg;
    logic [NPW-1:0] n_prod_reg;
    logic [NPW-1:0] n_round;
    logic [gcd_pkg::DIST_W-1:0] dist_reg;

    assign n_round  = (n_prod_reg + DHALF) >> (W - 4);
    assign distance = dist_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (vz_reg[N] < 0)
            begin
                m_a_reg <= '0;
            end
            else if (vz_reg[N] > PI_W)
            begin
                m_a_reg <= AW'(PI_W);
            end
            else
            begin
                m_a_reg <= AW'(vz_reg[N]);
            end
            n_prod_reg <= NPW'(radius_reg) * NPW'(m_a_reg);
            dist_reg   <= n_round[gcd_pkg::DIST_W-1:0];
        end
    end

endmodule

`default_nettype wire
